@@ src/pcle_pkg.sv @@
package pcle_pkg;

    localparam int NODE_CNT = 256;
    localparam int AW       = 8;
    localparam int PW       = 9;
    localparam int LIST_CNT = 16;
    localparam int HW       = 4;
    localparam int HPW      = 5;
    localparam int IW       = 32;
    localparam int CW       = 9;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    localparam logic [PW-1:0]  NIL_NODE = 9'd256;
    localparam logic [HPW-1:0] NIL_LIST = 5'd16;

    localparam logic [1:0] POS_BEFORE = 2'd0;
    localparam logic [1:0] POS_AFTER  = 2'd1;
    localparam logic [1:0] POS_ON     = 2'd2;

    typedef enum logic [3:0] {
        CMD_CREATE  = 4'd0,
        CMD_COUNT   = 4'd1,
        CMD_FIRST   = 4'd2,
        CMD_LAST    = 4'd3,
        CMD_NEXT    = 4'd4,
        CMD_PREV    = 4'd5,
        CMD_CURR    = 4'd6,
        CMD_INS_AFT = 4'd7,
        CMD_INS_BEF = 4'd8,
        CMD_APPEND  = 4'd9,
        CMD_PREPEND = 4'd10,
        CMD_REMOVE  = 4'd11,
        CMD_TRIM    = 4'd12,
        CMD_CONCAT  = 4'd13,
        CMD_FREE    = 4'd14,
        CMD_SEARCH  = 4'd15
    } cmd_t;

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_INIT = 15'b000000000000010,
        ST_DEC  = 15'b000000000000100,
        ST_NAV  = 15'b000000000001000,
        ST_ITEM = 15'b000000000010000,
        ST_INS1 = 15'b000000000100000,
        ST_INS2 = 15'b000000001000000,
        ST_INSW = 15'b000000010000000,
        ST_INSL = 15'b000000100000000,
        ST_RM1  = 15'b000001000000000,
        ST_TR1  = 15'b000010000000000,
        ST_GIVE = 15'b000100000000000,
        ST_CG   = 15'b001000000000000,
        ST_SR1  = 15'b010000000000000,
        ST_FIN  = 15'b100000000000000
    } state_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       in_fire;
        logic       live;
        logic       sz0;
        logic [1:0] pos;
        logic       fn_nil;
        logic       cat_ok;
        logic       start_nil;
        logic       nav_nil;
        logic       need_nb;
        logic       match;
        logic       q_next_nil;
        logic       init_last;
        logic       out_free;
    } stat_t;

endpackage

@@ src/pcle_ctrl.sv @@
module pcle_ctrl
    import pcle_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  stat_t  stat,
    output state_t state
);

    state_t state_reg, state_next;

    assign state = state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (stat.in_fire) state_next = ST_DEC;
            end
            ST_INIT: begin
                if (stat.init_last) state_next = ST_IDLE;
            end
            ST_DEC: begin
                state_next = ST_FIN;
                if (stat.cmd != CMD_CREATE && stat.live) begin
                    case (stat.cmd)
                        CMD_FIRST, CMD_LAST: begin
                            if (!stat.sz0) state_next = ST_ITEM;
                        end
                        CMD_NEXT: begin
                            if (!stat.sz0 && stat.pos == POS_BEFORE) state_next = ST_ITEM;
                            else if (!stat.sz0 && stat.pos == POS_ON) state_next = ST_NAV;
                        end
                        CMD_PREV: begin
                            if (!stat.sz0 && stat.pos == POS_AFTER) state_next = ST_ITEM;
                            else if (!stat.sz0 && stat.pos == POS_ON) state_next = ST_NAV;
                        end
                        CMD_CURR: begin
                            if (!stat.sz0 && stat.pos == POS_ON) state_next = ST_ITEM;
                        end
                        CMD_INS_AFT, CMD_INS_BEF, CMD_APPEND, CMD_PREPEND: begin
                            if (!stat.fn_nil) state_next = ST_INS1;
                        end
                        CMD_REMOVE: begin
                            if (!stat.sz0 && stat.pos == POS_ON) state_next = ST_RM1;
                        end
                        CMD_TRIM: begin
                            if (!stat.sz0) state_next = ST_TR1;
                        end
                        CMD_CONCAT: begin
                            if (stat.cat_ok) state_next = ST_CG;
                        end
                        CMD_SEARCH: begin
                            if (!stat.sz0 && stat.pos != POS_AFTER && !stat.start_nil)
                                state_next = ST_SR1;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_NAV:  state_next = stat.nav_nil ? ST_FIN : ST_ITEM;
            ST_ITEM: state_next = ST_FIN;
            ST_INS1: state_next = stat.need_nb ? ST_INS2 : ST_INSW;
            ST_INS2: state_next = ST_INSW;
            ST_INSW: state_next = ST_INSL;
            ST_INSL: state_next = ST_FIN;
            ST_RM1:  state_next = ST_GIVE;
            ST_TR1:  state_next = ST_GIVE;
            ST_GIVE: state_next = ST_FIN;
            ST_CG:   state_next = ST_FIN;
            ST_SR1: begin
                if (stat.match || stat.q_next_nil) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ src/pcle_dp.sv @@
module pcle_dp
    import pcle_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  state_t           st,
    output stat_t            stat,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IW-1:0]    cfg_data
);

    // List table, one entry per handle.
    logic [PW-1:0]       tf_reg [LIST_CNT];
    logic [PW-1:0]       tl_reg [LIST_CNT];
    logic [PW-1:0]       tc_reg [LIST_CNT];
    logic [1:0]          tp_reg [LIST_CNT];
    logic [CW-1:0]       ts_reg [LIST_CNT];
    logic [HPW-1:0]      tlink_reg [LIST_CNT];
    logic [LIST_CNT-1:0] tlive_reg;

    // Node pool memories.
    logic [PW-1:0] mem_next [NODE_CNT];
    logic [PW-1:0] mem_prev [NODE_CNT];
    logic [IW-1:0] mem_item [NODE_CNT];
    logic [PW-1:0] q_next_reg, q_prev_reg;
    logic [IW-1:0] q_item_reg;

    cmd_t           cmd_reg, cmd_next;
    logic [HW-1:0]  h_reg, h_next, h2_reg, h2_next;
    logic [IW-1:0]  val_reg, val_next;
    logic [PW-1:0]  wf_reg, wf_next, wl_reg, wl_next, wc_reg, wc_next;
    logic [1:0]     wp_reg, wp_next;
    logic [CW-1:0]  ws_reg, ws_next;
    logic           wlive_reg, wlive_next;
    logic [PW-1:0]  fn_reg, fn_next;
    logic [HPW-1:0] fh_reg, fh_next;
    logic [PW-1:0]  nd_reg, nd_next;
    logic [PW-1:0]  nnn_reg, nnn_next, nnp_reg, nnp_next;
    logic [PW-1:0]  wa_reg, wa_next, wb_reg, wb_next;
    logic [IW-1:0]  item_reg, item_next;
    logic           ok_reg, ok_next;
    logic [HW-1:0]  newh_reg, newh_next;
    logic           wben_reg, wben_next;
    logic           zrep_reg, zrep_next;
    logic [AW-1:0]  icnt_reg, icnt_next;
    logic [IW-1:0]  mask_reg;
    logic           mv_reg, mv_next;
    logic [OUT_W-1:0] out_reg, out_next;

    logic           in_fire, out_free;
    logic [HW-1:0]  tr_addr;
    logic [AW-1:0]  rd_addr;
    logic           nx_we, pv_we, it_we;
    logic [AW-1:0]  nx_wa, pv_wa, it_wa;
    logic [PW-1:0]  nx_wd, pv_wd;
    logic           tw_en, lk_en;
    logic [HW-1:0]  tw_addr, lk_addr;
    logic [PW-1:0]  tw_f, tw_l, tw_c;
    logic [1:0]     tw_p;
    logic [CW-1:0]  tw_s;
    logic           tw_live;
    logic [HPW-1:0] lk_data;

    logic           sz0, cat_ok, need_nb, match;
    logic [PW-1:0]  start_ptr, nav_link;

    assign s_tready  = (st == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !mv_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = out_reg;
    assign tr_addr   = (st == ST_IDLE) ? s_tdata[7:4] : h2_reg;

    assign sz0       = (ws_reg == '0);
    assign cat_ok    = tlive_reg[tr_addr] && (h2_reg != h_reg);
    assign need_nb   = !sz0 && (cmd_reg == CMD_INS_AFT || cmd_reg == CMD_INS_BEF)
                       && (wp_reg == POS_ON);
    assign match     = ((q_item_reg ^ val_reg) & mask_reg) == '0;
    assign start_ptr = (wp_reg == POS_BEFORE) ? wf_reg : wc_reg;
    assign nav_link  = (cmd_reg == CMD_PREV) ? q_prev_reg : q_next_reg;

    always_comb begin
        stat            = '0;
        stat.cmd        = cmd_reg;
        stat.in_fire    = in_fire;
        stat.live       = wlive_reg;
        stat.sz0        = sz0;
        stat.pos        = wp_reg;
        stat.fn_nil     = fn_reg[AW];
        stat.cat_ok     = cat_ok;
        stat.start_nil  = start_ptr[AW];
        stat.nav_nil    = nav_link[AW];
        stat.need_nb    = need_nb;
        stat.match      = match;
        stat.q_next_nil = q_next_reg[AW];
        stat.init_last  = (icnt_reg == '1);
        stat.out_free   = out_free;
    end

    always_comb begin
        logic          front, back;
        logic [PW-1:0] la, lb, p, n;
        cmd_next   = cmd_reg;   h_next   = h_reg;   h2_next = h2_reg;
        val_next   = val_reg;   wf_next  = wf_reg;  wl_next = wl_reg;
        wc_next    = wc_reg;    wp_next  = wp_reg;  ws_next = ws_reg;
        wlive_next = wlive_reg; fn_next  = fn_reg;  fh_next = fh_reg;
        nd_next    = nd_reg;    nnn_next = nnn_reg; nnp_next = nnp_reg;
        wa_next    = wa_reg;    wb_next  = wb_reg;  item_next = item_reg;
        ok_next    = ok_reg;    newh_next = newh_reg;
        wben_next  = wben_reg;  zrep_next = zrep_reg;
        icnt_next  = icnt_reg;  out_next = out_reg;
        mv_next    = (mv_reg && !m_tready);
        rd_addr    = nd_reg[AW-1:0];
        nx_we = 1'b0; nx_wa = '0; nx_wd = NIL_NODE;
        pv_we = 1'b0; pv_wa = '0; pv_wd = NIL_NODE;
        it_we = 1'b0; it_wa = '0;
        tw_en = 1'b0; tw_addr = h_reg;
        tw_f = wf_reg; tw_l = wl_reg; tw_c = wc_reg; tw_p = wp_reg;
        tw_s = ws_reg; tw_live = wlive_reg;
        lk_en = 1'b0; lk_addr = h_reg; lk_data = fh_reg;
        front = 1'b0; back = 1'b0;
        la = wc_reg; lb = q_next_reg;
        p = q_prev_reg; n = q_next_reg;

        case (st)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd_next   = cmd_t'(s_tdata[3:0]);
                    h_next     = s_tdata[7:4];
                    h2_next    = s_tdata[11:8];
                    val_next   = s_tdata[43:12];
                    wf_next    = tf_reg[tr_addr];
                    wl_next    = tl_reg[tr_addr];
                    wc_next    = tc_reg[tr_addr];
                    wp_next    = tp_reg[tr_addr];
                    ws_next    = ts_reg[tr_addr];
                    wlive_next = tlive_reg[tr_addr];
                    ok_next    = 1'b0;
                    item_next  = '0;
                    newh_next  = '0;
                    wben_next  = 1'b0;
                    zrep_next  = 1'b0;
                end
            end
            ST_INIT: begin
                nx_we = 1'b1; nx_wa = icnt_reg; nx_wd = {1'b0, icnt_reg} + PW'(1);
                pv_we = 1'b1; pv_wa = icnt_reg; pv_wd = NIL_NODE;
                icnt_next = icnt_reg + AW'(1);
            end
            ST_DEC: begin
                if (cmd_reg == CMD_CREATE) begin
                    if (!fh_reg[HW]) begin
                        fh_next    = tlink_reg[fh_reg[HW-1:0]];
                        lk_en      = 1'b1;
                        lk_addr    = fh_reg[HW-1:0];
                        lk_data    = NIL_LIST;
                        h_next     = fh_reg[HW-1:0];
                        newh_next  = fh_reg[HW-1:0];
                        wf_next    = NIL_NODE; wl_next = NIL_NODE; wc_next = NIL_NODE;
                        wp_next    = POS_BEFORE; ws_next = '0; wlive_next = 1'b1;
                        wben_next  = 1'b1;
                        ok_next    = 1'b1;
                    end else begin
                        zrep_next = 1'b1;
                    end
                end else if (!wlive_reg) begin
                    zrep_next = 1'b1;
                end else begin
                    wben_next = 1'b1;
                    case (cmd_reg)
                        CMD_COUNT: ok_next = 1'b1;
                        CMD_FIRST, CMD_LAST: begin
                            la = (cmd_reg == CMD_FIRST) ? wf_reg : wl_reg;
                            rd_addr = la[AW-1:0];
                            if (!sz0) begin
                                wc_next = la;
                                wp_next = POS_ON;
                            end
                        end
                        CMD_NEXT: begin
                            if (sz0) begin
                                wp_next = POS_AFTER;
                            end else if (wp_reg == POS_BEFORE) begin
                                wc_next = wf_reg; wp_next = POS_ON;
                                rd_addr = wf_reg[AW-1:0];
                            end else begin
                                rd_addr = wc_reg[AW-1:0];
                            end
                        end
                        CMD_PREV: begin
                            if (sz0) begin
                                wp_next = POS_BEFORE;
                            end else if (wp_reg == POS_AFTER) begin
                                wc_next = wl_reg; wp_next = POS_ON;
                                rd_addr = wl_reg[AW-1:0];
                            end else begin
                                rd_addr = wc_reg[AW-1:0];
                            end
                        end
                        CMD_CURR: rd_addr = wc_reg[AW-1:0];
                        CMD_INS_AFT, CMD_INS_BEF, CMD_APPEND, CMD_PREPEND: begin
                            nd_next = fn_reg;
                            rd_addr = fn_reg[AW-1:0];
                        end
                        CMD_REMOVE: begin
                            nd_next = wc_reg;
                            rd_addr = wc_reg[AW-1:0];
                        end
                        CMD_TRIM: begin
                            nd_next = wl_reg;
                            rd_addr = wl_reg[AW-1:0];
                        end
                        CMD_CONCAT: begin
                            if (cat_ok) begin
                                ok_next = 1'b1;
                                if (ts_reg[tr_addr] != '0) begin
                                    if (sz0) begin
                                        wf_next = tf_reg[tr_addr];
                                        wc_next = tf_reg[tr_addr];
                                        wp_next = POS_BEFORE;
                                    end else begin
                                        nx_we = !wl_reg[AW];
                                        nx_wa = wl_reg[AW-1:0];
                                        nx_wd = tf_reg[tr_addr];
                                        pv_we = !tf_reg[tr_addr][AW];
                                        pv_wa = tf_reg[tr_addr][AW-1:0];
                                        pv_wd = wl_reg;
                                        if (wp_reg == POS_AFTER) wc_next = tl_reg[tr_addr];
                                    end
                                    wl_next = tl_reg[tr_addr];
                                    ws_next = ws_reg + ts_reg[tr_addr];
                                end
                            end
                        end
                        CMD_FREE: begin
                            if (!sz0) begin
                                nx_we = !wl_reg[AW];
                                nx_wa = wl_reg[AW-1:0];
                                nx_wd = fn_reg;
                                fn_next = wf_reg;
                            end
                            lk_en = 1'b1; lk_addr = h_reg; lk_data = fh_reg;
                            fh_next = {1'b0, h_reg};
                            wf_next = NIL_NODE; wl_next = NIL_NODE; wc_next = NIL_NODE;
                            wp_next = POS_BEFORE; ws_next = '0; wlive_next = 1'b0;
                            ok_next = 1'b1;
                        end
                        default: begin
                            // Forward search.
                            if (sz0 || wp_reg == POS_AFTER) begin
                                wp_next = POS_AFTER;
                            end else if (start_ptr[AW]) begin
                                wc_next = wl_reg; wp_next = POS_AFTER;
                            end else begin
                                nd_next = start_ptr;
                                rd_addr = start_ptr[AW-1:0];
                            end
                        end
                    endcase
                end
            end
            ST_NAV: begin
                rd_addr = nav_link[AW-1:0];
                if (nav_link[AW]) begin
                    wp_next = (cmd_reg == CMD_PREV) ? POS_BEFORE : POS_AFTER;
                end else begin
                    wc_next = nav_link;
                end
            end
            ST_ITEM: begin
                item_next = q_item_reg;
                ok_next   = 1'b1;
            end
            ST_INS1: begin
                fn_next = q_next_reg;
                rd_addr = wc_reg[AW-1:0];
            end
            ST_INSW: begin
                nx_we = 1'b1; nx_wa = nd_reg[AW-1:0]; nx_wd = nnn_reg;
                pv_we = 1'b1; pv_wa = nd_reg[AW-1:0]; pv_wd = nnp_reg;
                it_we = 1'b1; it_wa = nd_reg[AW-1:0];
            end
            ST_INSL: begin
                nx_we = !wa_reg[AW]; nx_wa = wa_reg[AW-1:0]; nx_wd = nd_reg;
                pv_we = !wb_reg[AW]; pv_wa = wb_reg[AW-1:0]; pv_wd = nd_reg;
            end
            ST_RM1: begin
                item_next = q_item_reg;
                if (!p[AW]) begin
                    nx_we = 1'b1; nx_wa = p[AW-1:0]; nx_wd = n;
                end else begin
                    wf_next = n;
                end
                if (!n[AW]) begin
                    pv_we = 1'b1; pv_wa = n[AW-1:0]; pv_wd = p;
                    wc_next = n;
                end else begin
                    wl_next = p;
                    wc_next = p;
                    wp_next = POS_AFTER;
                end
            end
            ST_TR1: begin
                item_next = q_item_reg;
                if (p[AW]) begin
                    wf_next = NIL_NODE; wl_next = NIL_NODE; wc_next = NIL_NODE;
                    wp_next = POS_BEFORE;
                end else begin
                    nx_we = 1'b1; nx_wa = p[AW-1:0]; nx_wd = NIL_NODE;
                    wl_next = p; wc_next = p; wp_next = POS_ON;
                end
            end
            ST_GIVE: begin
                nx_we = !nd_reg[AW]; nx_wa = nd_reg[AW-1:0]; nx_wd = fn_reg;
                pv_we = !nd_reg[AW]; pv_wa = nd_reg[AW-1:0]; pv_wd = NIL_NODE;
                fn_next = nd_reg;
                ws_next = ws_reg - CW'(1);
                ok_next = 1'b1;
            end
            ST_CG: begin
                tw_en = 1'b1; tw_addr = h2_reg;
                tw_f = NIL_NODE; tw_l = NIL_NODE; tw_c = NIL_NODE;
                tw_p = POS_BEFORE; tw_s = '0; tw_live = 1'b0;
                lk_en = 1'b1; lk_addr = h2_reg; lk_data = fh_reg;
                fh_next = {1'b0, h2_reg};
            end
            ST_SR1: begin
                if (match) begin
                    wc_next = nd_reg; wp_next = POS_ON;
                    item_next = q_item_reg; ok_next = 1'b1;
                end else if (q_next_reg[AW]) begin
                    wc_next = wl_reg; wp_next = POS_AFTER;
                end else begin
                    nd_next = q_next_reg;
                    rd_addr = q_next_reg[AW-1:0];
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    tw_en    = wben_reg;
                    mv_next  = 1'b1;
                    out_next = {zrep_reg ? 2'b00 : wp_reg,
                                zrep_reg ? {CW{1'b0}} : ws_reg,
                                newh_reg,
                                ok_reg ? item_reg : {IW{1'b0}},
                                !ok_reg};
                end
            end
            default: begin
                mv_next = mv_reg && !m_tready;
            end
        endcase

        // Link decision for the new node of an insert.
        if ((st == ST_INS1 && !need_nb) || st == ST_INS2) begin
            front = sz0 || cmd_reg == CMD_PREPEND
                    || ((cmd_reg == CMD_INS_AFT || cmd_reg == CMD_INS_BEF)
                        && wp_reg == POS_BEFORE)
                    || (cmd_reg == CMD_INS_BEF && wp_reg == POS_ON && q_prev_reg[AW]);
            back  = !front && (cmd_reg == CMD_APPEND || wp_reg == POS_AFTER
                    || (cmd_reg == CMD_INS_AFT && wp_reg == POS_ON && q_next_reg[AW]));
            la = (cmd_reg == CMD_INS_AFT) ? wc_reg : q_prev_reg;
            lb = (cmd_reg == CMD_INS_AFT) ? q_next_reg : wc_reg;
            if (front && sz0) begin
                nnn_next = NIL_NODE; nnp_next = NIL_NODE;
                wa_next = NIL_NODE;  wb_next = NIL_NODE;
                wf_next = nd_reg;    wl_next = nd_reg;
            end else if (front) begin
                nnn_next = wf_reg;   nnp_next = NIL_NODE;
                wa_next = NIL_NODE;  wb_next = wf_reg;
                wf_next = nd_reg;
            end else if (back) begin
                nnn_next = NIL_NODE; nnp_next = wl_reg;
                wa_next = wl_reg;    wb_next = NIL_NODE;
                wl_next = nd_reg;
            end else begin
                nnn_next = lb;       nnp_next = la;
                wa_next = la;        wb_next = lb;
            end
            wc_next = nd_reg;
            wp_next = POS_ON;
            ws_next = ws_reg + CW'(1);
            ok_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (nx_we) mem_next[nx_wa] <= nx_wd;
        if (pv_we) mem_prev[pv_wa] <= pv_wd;
        if (it_we) mem_item[it_wa] <= val_reg;
        q_next_reg <= mem_next[rd_addr];
        q_prev_reg <= mem_prev[rd_addr];
        q_item_reg <= mem_item[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LIST_CNT; i++) begin
                tf_reg[i]    <= NIL_NODE;
                tl_reg[i]    <= NIL_NODE;
                tc_reg[i]    <= NIL_NODE;
                tp_reg[i]    <= POS_BEFORE;
                ts_reg[i]    <= '0;
                tlink_reg[i] <= HPW'(i + 1);
            end
            tlive_reg <= '0;
            fn_reg    <= '0;
            fh_reg    <= '0;
            icnt_reg  <= '0;
            mask_reg  <= '1;
            mv_reg    <= 1'b0;
        end else begin
            if (tw_en) begin
                tf_reg[tw_addr]    <= tw_f;
                tl_reg[tw_addr]    <= tw_l;
                tc_reg[tw_addr]    <= tw_c;
                tp_reg[tw_addr]    <= tw_p;
                ts_reg[tw_addr]    <= tw_s;
                tlive_reg[tw_addr] <= tw_live;
            end
            if (lk_en) tlink_reg[lk_addr] <= lk_data;
            if (cfg_valid) mask_reg <= cfg_data;
            fn_reg   <= fn_next;
            fh_reg   <= fh_next;
            icnt_reg <= icnt_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;   h_reg    <= h_next;    h2_reg  <= h2_next;
        val_reg   <= val_next;   wf_reg   <= wf_next;   wl_reg  <= wl_next;
        wc_reg    <= wc_next;    wp_reg   <= wp_next;   ws_reg  <= ws_next;
        wlive_reg <= wlive_next; nd_reg   <= nd_next;   nnn_reg <= nnn_next;
        nnp_reg   <= nnp_next;   wa_reg   <= wa_next;   wb_reg  <= wb_next;
        item_reg  <= item_next;  ok_reg   <= ok_next;   newh_reg <= newh_next;
        wben_reg  <= wben_next;  zrep_reg <= zrep_next; out_reg <= out_next;
    end

endmodule

@@ src/pooled_cursor_list_engine_unit.sv @@
// Channel  | Direction | Accept           | Payload
// s_       | in        | s_tvalid&s_tready| tdata: cmd, list_handle, second_handle, item_value
// m_       | out       | m_tvalid&m_tready| tdata: status, result_item, new_handle,
//          |           |                  |        list_count, cursor_state
// cfg_     | in        | cfg_valid&cfg_ready | match_mask
//
// One command is in work at a time. Search walks the visited nodes one
// after another, set by the single read port of the node memories.
// After reset the node chain is built one node per cycle,
// while s_tready stays low; configuration writes are taken meanwhile.
// A result waits in the output register while the next command is accepted.
module pooled_cursor_list_engine_unit
    import pcle_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [3:0] cmd, [7:4] list_handle, [11:8] second_handle, [43:12] item_value
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [0] status, [32:1] result_item, [36:33] new_handle, [45:37] list_count,
    // [47:46] cursor_state
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IW-1:0]    cfg_data
);

    // The controller steps through the micro-sequence of each command and
    // the datapath holds the list table, node pool memories and result.
    state_t state;
    stat_t  stat;

    pcle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .state   (state)
    );

    pcle_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .st        (state),
        .stat      (stat),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

@@ src/pcle_checker.sv @@
module pcle_checker
    import pcle_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while one is in work");

    a_pos_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:46] != 2'b11)
        else $error("bad cursor position");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[45] && (m_tdata[44:37] != 8'd0)))
        else $error("count above pool size");

    a_fail_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[32:1] == 32'd0)
        else $error("failed command returned an item");

endmodule

bind pooled_cursor_list_engine_unit pcle_checker u_pcle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_pooled_cursor_list_engine_unit.sv @@
`timescale 1ns / 1ps

module tb_pooled_cursor_list_engine_unit;
    import pcle_pkg::*;

    // One result transfer, split into its fields.
    typedef struct {
        logic        status;
        logic [31:0] item;
        logic [3:0]  newh;
        logic [8:0]  count;
        logic [1:0]  cstate;
    } reply_t;

    // One row of the directed table. When fixed is set, the row carries its
    // own expected reply; otherwise the list predictor supplies it.
    typedef struct {
        cmd_t        cmd;
        logic [3:0]  lh;
        logic [3:0]  h2;
        logic [31:0] val;
        bit          fixed;
        reply_t      want;
    } row_t;

    localparam int NNIL = 256;
    localparam int LNIL = 16;
    localparam int PHASES = 4;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IW-1:0]     cfg_data;

    pooled_cursor_list_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Mirror of the engine state: node pool, handle pool and per-list fields.
    int          nd_next [NNIL];
    int          nd_prev [NNIL];
    logic [31:0] nd_val  [NNIL];
    int          free_nd;
    int          hnd_link [LIST_CNT];
    int          free_hnd;
    int          l_head [LIST_CNT];
    int          l_tail [LIST_CNT];
    int          l_cur  [LIST_CNT];
    logic [1:0]  l_pos  [LIST_CNT];
    int          l_cnt  [LIST_CNT];
    bit          l_open [LIST_CNT];
    logic [31:0] mask_q;

    reply_t      replies_due[$];
    int          errors;
    int          checked;
    int          hits_found;
    bit          rx_calm;
    int          stall_left;

    function automatic int nd_after(int n);
        return (n < NNIL) ? nd_next[n] : NNIL;
    endfunction

    function automatic int nd_before(int n);
        return (n < NNIL) ? nd_prev[n] : NNIL;
    endfunction

    function automatic logic [31:0] nd_item(int n);
        return (n < NNIL) ? nd_val[n] : 32'd0;
    endfunction

    function automatic void put_next(int n, int v);
        if (n < NNIL) nd_next[n] = v;
    endfunction

    function automatic void put_prev(int n, int v);
        if (n < NNIL) nd_prev[n] = v;
    endfunction

    function automatic void mirror_reset();
        for (int i = 0; i < NNIL; i++) begin
            nd_next[i] = i + 1;
            nd_prev[i] = NNIL;
            nd_val[i]  = '0;
        end
        free_nd = 0;
        for (int i = 0; i < LIST_CNT; i++) begin
            hnd_link[i] = i + 1;
            l_head[i] = NNIL;
            l_tail[i] = NNIL;
            l_cur[i]  = NNIL;
            l_pos[i]  = POS_BEFORE;
            l_cnt[i]  = 0;
            l_open[i] = 0;
        end
        free_hnd = 0;
        mask_q = '1;
    endfunction

    function automatic void link_head(int h, int n);
        if (l_cnt[h] == 0) begin
            l_head[h] = n;
            l_tail[h] = n;
        end else begin
            put_prev(l_head[h], n);
            put_next(n, l_head[h]);
            l_head[h] = n;
        end
    endfunction

    function automatic void link_tail(int h, int n);
        if (l_cnt[h] == 0) begin
            link_head(h, n);
        end else begin
            put_next(l_tail[h], n);
            put_prev(n, l_tail[h]);
            l_tail[h] = n;
        end
    endfunction

    function automatic void link_behind(int a, int n);
        int b;
        b = nd_after(a);
        put_next(a, n);
        put_prev(n, a);
        put_next(n, b);
        put_prev(b, n);
    endfunction

    // Places a new node by cursor position; false when the node pool is dry.
    function automatic bit list_insert(int h, logic [31:0] v, cmd_t op);
        int n;
        int c;
        c = l_cur[h];
        n = free_nd;
        if (n >= NNIL) return 0;
        free_nd = nd_next[n];
        nd_next[n] = NNIL;
        nd_prev[n] = NNIL;
        nd_val[n] = v;
        if (l_cnt[h] == 0 || op == CMD_PREPEND) begin
            link_head(h, n);
        end else if (op == CMD_APPEND) begin
            link_tail(h, n);
        end else if (op == CMD_INS_AFT) begin
            if (l_pos[h] == POS_BEFORE) link_head(h, n);
            else if (l_pos[h] == POS_AFTER || nd_after(c) == NNIL) link_tail(h, n);
            else link_behind(c, n);
        end else begin
            if (l_pos[h] == POS_BEFORE) link_head(h, n);
            else if (l_pos[h] == POS_AFTER) link_tail(h, n);
            else if (nd_before(c) == NNIL) link_head(h, n);
            else link_behind(nd_before(c), n);
        end
        l_cur[h] = n;
        l_pos[h] = POS_ON;
        l_cnt[h]++;
        return 1;
    endfunction

    function automatic void release_handle(int h);
        l_head[h] = NNIL;
        l_tail[h] = NNIL;
        l_cur[h]  = NNIL;
        l_pos[h]  = POS_BEFORE;
        l_cnt[h]  = 0;
        l_open[h] = 0;
        hnd_link[h] = free_hnd;
        free_hnd = h;
    endfunction

    // Executes one command on the mirror and returns the reply it produces.
    function automatic reply_t list_command(cmd_t op, int h, int h2, logic [31:0] v);
        reply_t r;
        bit ok;
        int rep;
        int c;
        int n;
        int p;
        int sz;
        logic [1:0] pos;
        ok = 0;
        r.item = '0;
        r.newh = '0;
        rep = h;
        if (op == CMD_CREATE) begin
            rep = LNIL;
            if (free_hnd < LNIL) begin
                n = free_hnd;
                free_hnd = hnd_link[n];
                hnd_link[n] = LNIL;
                l_head[n] = NNIL;
                l_tail[n] = NNIL;
                l_cur[n]  = NNIL;
                l_pos[n]  = POS_BEFORE;
                l_cnt[n]  = 0;
                l_open[n] = 1;
                r.newh = 4'(n);
                rep = n;
                ok = 1;
            end
        end else if (!l_open[h]) begin
            rep = LNIL;
        end else begin
            c = l_cur[h];
            pos = l_pos[h];
            sz = l_cnt[h];
            case (op)
                CMD_COUNT: ok = 1;
                CMD_FIRST, CMD_LAST: begin
                    if (sz != 0) begin
                        l_cur[h] = (op == CMD_FIRST) ? l_head[h] : l_tail[h];
                        l_pos[h] = POS_ON;
                        r.item = nd_item(l_cur[h]);
                        ok = 1;
                    end
                end
                CMD_NEXT: begin
                    if (sz == 0) begin
                        l_pos[h] = POS_AFTER;
                    end else if (pos == POS_BEFORE) begin
                        l_cur[h] = l_head[h];
                        l_pos[h] = POS_ON;
                        r.item = nd_item(l_head[h]);
                        ok = 1;
                    end else if (pos == POS_ON) begin
                        if (nd_after(c) == NNIL) begin
                            l_pos[h] = POS_AFTER;
                        end else begin
                            l_cur[h] = nd_after(c);
                            r.item = nd_item(l_cur[h]);
                            ok = 1;
                        end
                    end
                end
                CMD_PREV: begin
                    if (sz == 0) begin
                        l_pos[h] = POS_BEFORE;
                    end else if (pos == POS_AFTER) begin
                        l_cur[h] = l_tail[h];
                        l_pos[h] = POS_ON;
                        r.item = nd_item(l_tail[h]);
                        ok = 1;
                    end else if (pos == POS_ON) begin
                        if (nd_before(c) == NNIL) begin
                            l_pos[h] = POS_BEFORE;
                        end else begin
                            l_cur[h] = nd_before(c);
                            r.item = nd_item(l_cur[h]);
                            ok = 1;
                        end
                    end
                end
                CMD_CURR: begin
                    if (sz != 0 && pos == POS_ON) begin
                        r.item = nd_item(c);
                        ok = 1;
                    end
                end
                CMD_INS_AFT, CMD_INS_BEF, CMD_APPEND, CMD_PREPEND:
                    ok = list_insert(h, v, op);
                CMD_REMOVE: begin
                    if (sz != 0 && pos == POS_ON) begin
                        p = nd_before(c);
                        n = nd_after(c);
                        r.item = nd_item(c);
                        if (p != NNIL) put_next(p, n); else l_head[h] = n;
                        if (n != NNIL) put_prev(n, p); else l_tail[h] = p;
                        if (n == NNIL) begin
                            l_cur[h] = p;
                            l_pos[h] = POS_AFTER;
                        end else begin
                            l_cur[h] = n;
                        end
                        nd_next[c] = free_nd;
                        nd_prev[c] = NNIL;
                        free_nd = c;
                        l_cnt[h] = sz - 1;
                        ok = 1;
                    end
                end
                CMD_TRIM: begin
                    if (sz != 0) begin
                        n = l_tail[h];
                        p = nd_before(n);
                        r.item = nd_item(n);
                        if (p == NNIL) begin
                            l_head[h] = NNIL;
                            l_tail[h] = NNIL;
                            l_cur[h]  = NNIL;
                            l_pos[h]  = POS_BEFORE;
                        end else begin
                            put_next(p, NNIL);
                            l_tail[h] = p;
                            l_cur[h]  = p;
                            l_pos[h]  = POS_ON;
                        end
                        nd_next[n] = free_nd;
                        nd_prev[n] = NNIL;
                        free_nd = n;
                        l_cnt[h] = sz - 1;
                        ok = 1;
                    end
                end
                CMD_CONCAT: begin
                    if (l_open[h2] && h2 != h) begin
                        if (l_cnt[h2] != 0) begin
                            if (sz == 0) begin
                                l_head[h] = l_head[h2];
                                l_tail[h] = l_tail[h2];
                                l_cur[h]  = l_head[h2];
                                l_pos[h]  = POS_BEFORE;
                            end else begin
                                put_next(l_tail[h], l_head[h2]);
                                put_prev(l_head[h2], l_tail[h]);
                                l_tail[h] = l_tail[h2];
                                if (pos == POS_AFTER) l_cur[h] = l_tail[h];
                            end
                            l_cnt[h] = sz + l_cnt[h2];
                        end
                        release_handle(h2);
                        ok = 1;
                    end
                end
                CMD_FREE: begin
                    if (sz != 0) begin
                        put_next(l_tail[h], free_nd);
                        free_nd = l_head[h];
                    end
                    release_handle(h);
                    ok = 1;
                end
                default: begin
                    // Search: forward walk from the cursor under the match mask.
                    if (sz == 0 || pos == POS_AFTER) begin
                        l_pos[h] = POS_AFTER;
                    end else begin
                        n = (pos == POS_BEFORE) ? l_head[h] : c;
                        for (int k = 0; k < NNIL && n != NNIL && !ok; k++) begin
                            if (((nd_item(n) ^ v) & mask_q) == 0) begin
                                l_cur[h] = n;
                                l_pos[h] = POS_ON;
                                r.item = nd_item(n);
                                ok = 1;
                            end else begin
                                n = nd_after(n);
                            end
                        end
                        if (!ok) begin
                            l_cur[h] = l_tail[h];
                            l_pos[h] = POS_AFTER;
                        end
                    end
                end
            endcase
        end
        r.status = !ok;
        if (!ok) r.item = '0;
        if (rep < LNIL) begin
            r.count  = 9'(l_cnt[rep]);
            r.cstate = l_pos[rep];
        end else begin
            r.count  = '0;
            r.cstate = '0;
        end
        return r;
    endfunction

    // Sends one command, predicts its reply at the accepting edge and
    // then leaves a random gap. A fixed row overrides the prediction.
    task automatic issue(cmd_t op, logic [3:0] h, logic [3:0] h2, logic [31:0] v,
                         bit fixed, reply_t want, bit no_gap);
        reply_t r;
        int g;
        s_tdata  <= {4'd0, v, h2, h, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = list_command(op, h, h2, v);
        if (op == CMD_SEARCH && !r.status) hits_found++;
        replies_due.push_back(fixed ? want : r);
        g = $urandom_range(0, 99);
        if (no_gap || g < 60) g = 0;
        else if (g < 92) g = $urandom_range(1, 3);
        else g = $urandom_range(8, 30);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic write_mask(logic [31:0] m);
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mask_q = m;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic int pick_open();
        int q[$];
        for (int i = 0; i < LIST_CNT; i++) if (l_open[i]) q.push_back(i);
        if (q.size() == 0 || $urandom_range(0, 99) < 8) return $urandom_range(0, 15);
        return q[$urandom_range(0, q.size() - 1)];
    endfunction

    // Keys and items come from a narrow set most of the time so that
    // searches hit; the rest are full-width values.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 7);
    endfunction

    // Result side: random stalls, with long ones now and then, and the
    // field-by-field comparison of every result transfer.
    always @(posedge aclk) begin
        reply_t got;
        reply_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[0];
            got.item   = m_tdata[32:1];
            got.newh   = m_tdata[36:33];
            got.count  = m_tdata[45:37];
            got.cstate = m_tdata[47:46];
            checked++;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $realtime, m_tdata);
                errors++;
            end else begin
                exp_r = replies_due.pop_front();
                if (got.status !== exp_r.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $realtime, exp_r.status, got.status);
                    errors++;
                end
                if (got.item !== exp_r.item) begin
                    $display("%0t: result_item expected %h got %h",
                             $realtime, exp_r.item, got.item);
                    errors++;
                end
                if (got.newh !== exp_r.newh) begin
                    $display("%0t: new_handle expected %0d got %0d",
                             $realtime, exp_r.newh, got.newh);
                    errors++;
                end
                if (got.count !== exp_r.count) begin
                    $display("%0t: list_count expected %0d got %0d",
                             $realtime, exp_r.count, got.count);
                    errors++;
                end
                if (got.cstate !== exp_r.cstate) begin
                    $display("%0t: cursor_state expected %0d got %0d",
                             $realtime, exp_r.cstate, got.cstate);
                    errors++;
                end
            end
        end
        if (rx_calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 4) stall_left = $urandom_range(8, 30);
            m_tready <= (r < 30) ? 1'b0 : 1'b1;
        end
    end

    initial begin
        #6000000;
        $display("Some tests failed");
        $finish;
    end

    row_t        plan[$];
    logic [31:0] masks[PHASES] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0003, 32'hF0F0_F0F5};

    initial begin
        reply_t z;
        reply_t fail0;
        cmd_t op;
        int r;
        int h;
        int budget;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        checked = 0;
        hits_found = 0;
        rx_calm = 0;
        stall_left = 0;
        mirror_reset();
        z = '{status: 1'b0, item: '0, newh: '0, count: '0, cstate: POS_BEFORE};
        fail0 = '{status: 1'b1, item: '0, newh: '0, count: '0, cstate: POS_BEFORE};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk: unopened handle, empty list slips, every command,
        // concat with itself and with a closed handle, then a freed handle.
        plan.push_back('{CMD_COUNT,   4'd0,  4'd0,  32'd0,        1, fail0});
        plan.push_back('{CMD_CREATE,  4'd15, 4'd15, 32'hFFFF_FFFF, 1, z});
        plan.push_back('{CMD_NEXT,    4'd0,  4'd0,  32'd0, 1,
                         '{1'b1, 32'd0, 4'd0, 9'd0, POS_AFTER}});
        plan.push_back('{CMD_PREV,    4'd0,  4'd0,  32'd0, 1,
                         '{1'b1, 32'd0, 4'd0, 9'd0, POS_BEFORE}});
        plan.push_back('{CMD_APPEND,  4'd0,  4'd0,  32'hFFFF_FFFF, 1,
                         '{1'b0, 32'd0, 4'd0, 9'd1, POS_ON}});
        plan.push_back('{CMD_PREPEND, 4'd0,  4'd0,  32'd0, 1,
                         '{1'b0, 32'd0, 4'd0, 9'd2, POS_ON}});
        plan.push_back('{CMD_INS_AFT, 4'd0,  4'd0,  32'h5A5A_5A5A, 0, z});
        plan.push_back('{CMD_INS_BEF, 4'd0,  4'd0,  32'hA5A5_A5A5, 0, z});
        plan.push_back('{CMD_FIRST,   4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_LAST,    4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_NEXT,    4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_NEXT,    4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_PREV,    4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_CURR,    4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_FIRST,   4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_SEARCH,  4'd0,  4'd0,  32'h5A5A_5A5A, 0, z});
        plan.push_back('{CMD_REMOVE,  4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_TRIM,    4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_CREATE,  4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_APPEND,  4'd1,  4'd0,  32'h1234_5678, 0, z});
        plan.push_back('{CMD_CONCAT,  4'd0,  4'd1,  32'd0, 0, z});
        plan.push_back('{CMD_CONCAT,  4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_CONCAT,  4'd0,  4'd15, 32'd0, 0, z});
        plan.push_back('{CMD_SEARCH,  4'd0,  4'd0,  32'h1234_5678, 0, z});
        plan.push_back('{CMD_FREE,    4'd0,  4'd0,  32'd0, 0, z});
        plan.push_back('{CMD_CURR,    4'd0,  4'd0,  32'd0, 1, fail0});

        // The mask is written during the post-reset clearing pass.
        write_mask(masks[0]);
        foreach (plan[i])
            issue(plan[i].cmd, plan[i].lh, plan[i].h2, plan[i].val,
                  plan[i].fixed, plan[i].want, 0);

        // Random phases, one mask setting each. Phase 1 leans on create and
        // runs with no idling at all; phase 3 leans on appends to drain the
        // node pool; phases 0 and 2 mix in frees to recycle it.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            write_mask(masks[ph]);
            rx_calm = (ph == 1);
            budget = 330;
            for (int k = 0; k < budget; k++) begin
                r = $urandom_range(0, 99);
                h = pick_open();
                if (r < ((ph == 1) ? 18 : 5)) op = CMD_CREATE;
                else if (r < ((ph == 3) ? 55 : 14) && ph == 3) op = CMD_APPEND;
                else if (r < 20) op = ($urandom_range(0, 2) == 0) ? CMD_FREE : CMD_CONCAT;
                else if (r < 50) op = cmd_t'($urandom_range(CMD_INS_AFT, CMD_PREPEND));
                else if (r < 60) op = ($urandom_range(0, 1) != 0) ? CMD_REMOVE : CMD_TRIM;
                else if (r < 84) op = cmd_t'($urandom_range(CMD_COUNT, CMD_CURR));
                else op = CMD_SEARCH;
                issue(op, 4'(h), 4'(pick_open()), pick_value(), 0, z, ph == 1);
            end
        end

        drain();
        $display("Covered %0d result transfers, %0d search hits, under %0d mask settings.",
                 checked, hits_found, PHASES);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
